[src/wda_pkg.sv]
package wda_pkg;

  // Largest device count handled; a larger request is saturated to it
  localparam int MAX_DEVICES = 64;
  localparam int NW          = $clog2(MAX_DEVICES + 1);
  localparam int CW          = 7;              // count and register width
  localparam int WW          = 17;             // Q1.16 weight width
  localparam int QW          = CW + 16;        // (count << 16) / N quotient width
  localparam int DW          = QW + 3;         // signed weight error width
  localparam int PW          = 2 * WW;         // shared multiplier product width

  localparam logic [WW-1:0] ONE_Q16   = WW'(65536);
  // floor(2^18 / 3), for division of an error magnitude by three
  localparam logic [WW-1:0] RECIP3    = WW'(87381);
  localparam int            RECIP3_SH = 18;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_READ_MIN   = 3'd0,
    REG_READ_MAX   = 3'd1,
    REG_WRITE_MIN  = 3'd2,
    REG_WRITE_MAX  = 3'd3,
    REG_FORMAT_MIN = 3'd4,
    REG_FORMAT_MAX = 3'd5
  } reg_idx_t;

  // min(max(x, lo), hi): the upper bound wins on an inverted range
  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] x,
                                              input logic [CW-1:0] lo,
                                              input logic [CW-1:0] hi);
    logic [CW-1:0] v;
    v = (x < lo) ? lo : x;
    return (v > hi) ? hi : v;
  endfunction

endpackage

[src/weighted_device_apportion.sv]
// Channel  | Signals                         | Transaction
// ---------+---------------------------------+-------------------------------------
// s        | s_tvalid s_tready s_tdata[71:0] | one request: N, min sum, flags, weights
// m        | m_tvalid m_tready m_tdata[23:0] | one result: three device counts
// cfg      | psel penable pwrite paddr ...   | min and max registers, pready tied high
//
// A request with N of 0, 1 or 2 goes from acceptance through S_SMALL to the output register.
// Otherwise it computes the initial counts with the shared multiplier, trims one device
// at a time, runs the restoring divider (one quotient bit a cycle) for each count and for
// one over N, then adds one device at a time, each through the error and spread steps.
// Reset is synchronous and restores min 0 and max 64 for every class.
// s_tready is high only while idle; a waiting result in the output register does not
// block the next request, and the finished counts wait until that register is free.
module weighted_device_apportion (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] device_count, [14:7] min_sum, [15] read_pending, [16] write_pending,
  // [17] format_pending, [34:18] read_weight, [51:35] write_weight,
  // [68:52] format_weight, [71:69] zero
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [6:0] read_count, [13:7] write_count, [20:14] format_count, [23:21] zero
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wda_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SMALL = 13'b0000000000010,
    S_MUL   = 13'b0000000000100,
    S_CLP   = 13'b0000000001000,
    S_TRIM  = 13'b0000000010000,
    S_DVL   = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_CHK   = 13'b0000010000000,
    S_ERR   = 13'b0000100000000,
    S_SPM   = 13'b0001000000000,
    S_SPF   = 13'b0010000000000,
    S_ADJ   = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  // configuration registers, index = class * 2 + (0 min, 1 max)
  logic [CW-1:0] cfg_reg [6];

  state_t state;
  logic          pick;           // choose-and-add cycle, after S_FIN
  logic          out_wait;       // counts final, waiting for the output register
  logic [NW-1:0] n;
  logic [2:0]    pend;
  logic [WW-1:0] w   [3];
  logic [CW-1:0] mn  [3];
  logic [CW-1:0] mx  [3];
  logic [CW-1:0] cnt [3];
  logic [QW-1:0] q   [3];
  logic [CW-1:0] r   [3];
  logic [QW-1:0] qone;
  logic [CW-1:0] rone;
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] acc;
  logic [2:0]    m;
  logic [1:0]    fr;
  logic [1:0]    k;
  logic [1:0]    job;
  logic [4:0]    bc;
  logic [QW-1:0] dquo;
  logic [CW-1:0] drem;
  logic [PW-1:0] prod;

  // ---------------- configuration port ----------------
  logic [2:0] cidx;
  assign cidx   = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    case (cidx)
      REG_READ_MIN:   prdata = {25'b0, cfg_reg[0]};
      REG_READ_MAX:   prdata = {25'b0, cfg_reg[1]};
      REG_WRITE_MIN:  prdata = {25'b0, cfg_reg[2]};
      REG_WRITE_MAX:  prdata = {25'b0, cfg_reg[3]};
      REG_FORMAT_MIN: prdata = {25'b0, cfg_reg[4]};
      REG_FORMAT_MAX: prdata = {25'b0, cfg_reg[5]};
      default:        prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cfg_reg[2*i]   <= '0;
        cfg_reg[2*i+1] <= CW'(MAX_DEVICES);
      end
    end else if (psel && penable && pwrite && pready && cidx <= REG_FORMAT_MAX) begin
      cfg_reg[cidx] <= pwdata[CW-1:0];
    end
  end

  // ---------------- request decode ----------------
  logic [6:0]    in_n;
  logic [7:0]    in_msum;
  logic [NW-1:0] n_sat;
  logic [WW-1:0] in_w [3];
  logic          narrow;

  assign in_n    = s_tdata[6:0];
  assign in_msum = s_tdata[14:7];
  assign n_sat   = (in_n > 7'(MAX_DEVICES)) ? NW'(MAX_DEVICES) : NW'(in_n);
  assign in_w[0] = s_tdata[34:18];
  assign in_w[1] = s_tdata[51:35];
  assign in_w[2] = s_tdata[68:52];
  assign narrow  = ({1'b0, n_sat} < in_msum) && (n_sat > NW'(2));
  assign s_tready = (state == S_IDLE) && !pick && !out_wait;

  // ---------------- shared multiplier ----------------
  logic [DW-1:0] negd;
  logic [WW-1:0] mag;
  logic [WW-1:0] mul_a;
  logic [WW-1:0] mul_b;

  assign negd = DW'(-d[k]);
  assign mag  = negd[WW-1:0];

  always_comb begin
    if (state == S_SPM) begin
      mul_a = mag;
      mul_b = RECIP3;
    end else begin
      mul_a = w[k];
      mul_b = WW'(n);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- small device counts ----------------
  logic [CW-1:0] sc  [3];
  logic [CW-1:0] sc2 [3];
  logic [2:0]    sm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc[i] = pend[i] ? clamp_cnt(CW'(1), mn[i], mx[i]) : '0;
      sm[i] = (sc[i] == mx[i]) || !pend[i];
      sc2[i] = sc[i];
    end
    if (n == NW'(2)) begin
      if (w[0] > w[1]) begin
        if (!sm[0] && w[0] > w[2])      sc2[0] = CW'(2);
        else if (!sm[2] && w[2] > w[1]) sc2[2] = CW'(2);
        else if (!sm[1])                sc2[1] = CW'(2);
      end else begin
        if (!sm[1] && w[1] > w[2])      sc2[1] = CW'(2);
        else if (!sm[2] && w[2] > w[1]) sc2[2] = CW'(2);
        else if (!sm[0])                sc2[0] = CW'(2);
      end
    end
    if (n == '0) begin
      for (int i = 0; i < 3; i++) sc2[i] = '0;
    end
  end

  // ---------------- shared datapath helpers ----------------
  logic [8:0]    sum;
  logic [2:0]    mask;
  logic [1:0]    free_c;
  logic [7:0]    trial;
  logic [CW-1:0] raw;
  logic [15:0]   q0;
  logic [17:0]   r3;
  logic [WW-1:0] quo;
  logic signed [DW-1:0] top;
  logic          spread_any;

  assign sum   = 9'(cnt[0]) + 9'(cnt[1]) + 9'(cnt[2]);
  assign trial = {drem, dquo[QW-1]};
  assign raw   = prod[16+CW-1:16];
  assign q0    = prod[RECIP3_SH+15:RECIP3_SH];
  assign r3    = 18'(mag) - (18'({q0, 1'b0}) + 18'(q0));

  always_comb begin
    for (int i = 0; i < 3; i++) mask[i] = (cnt[i] == mx[i]) || !pend[i];
    free_c = 2'(!mask[0]) + 2'(!mask[1]) + 2'(!mask[2]);
    spread_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (mask[i] && pend[i] && ($signed({3'b0, q[i]}) < $signed({9'b0, w[i]})))
        spread_any = 1'b1;
    end
    case (fr)
      2'd1:    quo = mag;
      2'd2:    quo = mag >> 1;
      default: quo = (r3 >= 18'd3) ? WW'(q0 + 16'd1) : WW'(q0);
    endcase
    top = (d[0] > d[1]) ? d[0] : d[1];
    if (d[2] > top) top = d[2];
    top = top + $signed({9'b0, ONE_Q16});
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pick     <= 1'b0;
      out_wait <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // deliver finished counts once the output register is free, else drop a taken result
      if (out_wait && (!m_tvalid || m_tready)) begin
        m_tdata  <= {3'b0, cnt[2], cnt[1], cnt[0]};
        m_tvalid <= 1'b1;
        out_wait <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (pick) begin
        // choose the most negative error and add one device
        pick <= 1'b0;
        if ((d[0] < 0 && d[0] < d[1]) || d[1] < 0 || d[2] < 0) begin
          logic [1:0]    sel;
          logic [CW:0]   rs;
          if (d[0] < 0 && d[0] < d[1]) sel = (d[0] < d[2]) ? 2'd0 : 2'd2;
          else if (d[1] < 0)           sel = (d[1] < d[2]) ? 2'd1 : 2'd2;
          else                         sel = 2'd2;
          rs = {1'b0, r[sel]} + {1'b0, rone};
          cnt[sel] <= cnt[sel] + CW'(1);
          if (rs >= (CW+1)'(n)) begin
            r[sel] <= CW'(rs - (CW+1)'(n));
            q[sel] <= q[sel] + qone + QW'(1);
          end else begin
            r[sel] <= CW'(rs);
            q[sel] <= q[sel] + qone;
          end
          state <= S_CHK;
        end else begin
          out_wait <= 1'b1;
          state    <= S_IDLE;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (s_tvalid && s_tready) begin
              n    <= n_sat;
              pend <= s_tdata[17:15];
              for (int i = 0; i < 3; i++) begin
                w[i]   <= (in_w[i] > ONE_Q16) ? ONE_Q16 : in_w[i];
                cnt[i] <= '0;
                if (narrow) begin
                  mx[i] <= cfg_reg[2*i];
                  mn[i] <= (cfg_reg[2*i] != '0) ? CW'(1) : '0;
                end else begin
                  mn[i] <= cfg_reg[2*i];
                  mx[i] <= cfg_reg[2*i+1];
                end
              end
              k     <= '0;
              state <= (n_sat <= NW'(2)) ? S_SMALL : S_MUL;
            end
          end
          S_SMALL: begin
            for (int i = 0; i < 3; i++) cnt[i] <= sc2[i];
            out_wait <= 1'b1;
            state    <= S_IDLE;
          end
          S_MUL: begin
            state <= S_CLP;
          end
          S_CLP: begin
            // initial count from floor(w * N)
            cnt[k] <= pend[k] ? clamp_cnt(raw, mn[k], mx[k]) : '0;
            if (k == 2'd2) state <= S_TRIM;
            else begin
              k     <= k + 2'd1;
              state <= S_MUL;
            end
          end
          S_TRIM: begin
            // drop one device, read first, while the total is over N
            if (sum > 9'(n) && (cnt[0] > mn[0] || cnt[1] > mn[1] || cnt[2] > mn[2])) begin
              if (cnt[0] > mn[0])      cnt[0] <= cnt[0] - CW'(1);
              else if (cnt[1] > mn[1]) cnt[1] <= cnt[1] - CW'(1);
              else                     cnt[2] <= cnt[2] - CW'(1);
            end else begin
              job   <= '0;
              state <= S_DVL;
            end
          end
          S_DVL: begin
            dquo  <= (job == 2'd3) ? QW'(ONE_Q16) : {cnt[job], 16'b0};
            drem  <= '0;
            bc    <= '0;
            state <= S_DIV;
          end
          S_DIV: begin
            // one quotient bit per cycle
            if (trial >= 8'(n)) begin
              drem <= CW'(trial - 8'(n));
              dquo <= {dquo[QW-2:0], 1'b1};
            end else begin
              drem <= trial[CW-1:0];
              dquo <= {dquo[QW-2:0], 1'b0};
            end
            if (bc == 5'(QW-1)) begin
              if (trial >= 8'(n)) begin
                if (job == 2'd3) begin
                  qone <= {dquo[QW-2:0], 1'b1};
                  rone <= CW'(trial - 8'(n));
                end else begin
                  q[job] <= {dquo[QW-2:0], 1'b1};
                  r[job] <= CW'(trial - 8'(n));
                end
              end else begin
                if (job == 2'd3) begin
                  qone <= {dquo[QW-2:0], 1'b0};
                  rone <= trial[CW-1:0];
                end else begin
                  q[job] <= {dquo[QW-2:0], 1'b0};
                  r[job] <= trial[CW-1:0];
                end
              end
              if (job == 2'd3) state <= S_CHK;
              else begin
                job   <= job + 2'd1;
                state <= S_DVL;
              end
            end else begin
              bc <= bc + 5'd1;
            end
          end
          S_CHK: begin
            if (sum >= 9'(n) || mask == 3'b111) begin
              out_wait <= 1'b1;
              state    <= S_IDLE;
            end else begin
              state <= S_ERR;
            end
          end
          S_ERR: begin
            // raw weight errors and the maxed set
            for (int i = 0; i < 3; i++)
              d[i] <= $signed({3'b0, q[i]}) - $signed({9'b0, w[i]});
            m     <= mask;
            fr    <= free_c;
            acc   <= '0;
            k     <= '0;
            state <= spread_any ? S_SPM : S_ADJ;
          end
          S_SPM: begin
            state <= S_SPF;
          end
          S_SPF: begin
            // spread a maxed class's deficit over the free classes
            if (m[k] && pend[k] && d[k] < 0)
              acc <= acc - $signed({9'b0, quo});
            if (k == 2'd2) state <= S_ADJ;
            else begin
              k     <= k + 2'd1;
              state <= S_SPM;
            end
          end
          S_ADJ: begin
            for (int i = 0; i < 3; i++) begin
              if (!m[i])        d[i] <= d[i] + acc;
              else if (pend[i]) d[i] <= '0;
            end
            state <= S_FIN;
          end
          S_FIN: begin
            // with no deficit anywhere, push free classes below the largest error
            if (d[0] >= 0 && d[1] >= 0 && d[2] >= 0) begin
              for (int i = 0; i < 3; i++)
                if (!m[i] && pend[i]) d[i] <= d[i] - top;
            end
            pick  <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

[sim/wda_checker.sv]
module wda_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          waiting,
  output int          results_seen
);
  import wda_pkg::*;

  logic [6:0]  lim_lo [3];
  logic [6:0]  lim_hi [3];
  logic [23:0] counts_q [$];

  // Work out the three device counts for one request
  function automatic logic [23:0] apportion(input logic [71:0] req);
    int n, msum, lo[3], hi[3], cnt[3], w[3], d[3];
    bit pend[3];
    bit run;
    int i, j, k, m, free_n, top;
    n = req[6:0];
    msum = req[14:7];
    if (n > MAX_DEVICES) n = MAX_DEVICES;
    for (i = 0; i < 3; i++) begin
      pend[i] = req[15+i];
      w[i] = req[18+17*i +: 17];
      if (w[i] > 65536) w[i] = 65536;
      lo[i] = lim_lo[i];
      hi[i] = lim_hi[i];
      cnt[i] = 0;
    end
    if (n > 0) begin
      // narrow the ranges when the mins cannot all be met
      if (n < msum && n > 2)
        for (i = 0; i < 3; i++) begin
          hi[i] = lo[i];
          lo[i] = (lo[i] < 1) ? lo[i] : 1;
        end
      if (n <= 2) begin
        for (i = 0; i < 3; i++) begin
          k = (1 < lo[i]) ? lo[i] : 1;
          cnt[i] = pend[i] ? ((k > hi[i]) ? hi[i] : k) : 0;
        end
        if (n == 2) begin
          m = 0;
          for (i = 0; i < 3; i++) if (cnt[i] == hi[i] || !pend[i]) m |= 1 << i;
          if (w[0] > w[1]) begin
            if (!m[0] && w[0] > w[2]) cnt[0] = 2;
            else if (!m[2] && w[2] > w[1]) cnt[2] = 2;
            else if (!m[1]) cnt[1] = 2;
          end else begin
            if (!m[1] && w[1] > w[2]) cnt[1] = 2;
            else if (!m[2] && w[2] > w[1]) cnt[2] = 2;
            else if (!m[0]) cnt[0] = 2;
          end
        end
      end else begin
        // initial share, then trim toward the mins
        for (i = 0; i < 3; i++) begin
          k = (w[i] * n) >>> 16;
          if (k < lo[i]) k = lo[i];
          if (k > hi[i]) k = hi[i];
          cnt[i] = pend[i] ? k : 0;
        end
        run = 1;
        while (run && cnt[0] + cnt[1] + cnt[2] > n) begin
          if (cnt[0] > lo[0]) cnt[0]--;
          else if (cnt[1] > lo[1]) cnt[1]--;
          else if (cnt[2] > lo[2]) cnt[2]--;
          else run = 0;
        end
        // hand out the rest one device at a time
        run = 1;
        for (k = 0; k < n && run; k++) begin
          m = 0;
          for (i = 0; i < 3; i++) if (cnt[i] == hi[i] || !pend[i]) m |= 1 << i;
          if (cnt[0] + cnt[1] + cnt[2] >= n || m == 7) begin
            run = 0;
          end else begin
            free_n = 0;
            for (i = 0; i < 3; i++) begin
              d[i] = ((cnt[i] << 16) / n) - w[i];
              if (!m[i]) free_n++;
            end
            for (i = 0; i < 3; i++)
              if (m[i] && pend[i]) begin
                if (d[i] < 0)
                  for (j = 0; j < 3; j++)
                    if (j != i && !m[j] && pend[j] && free_n > 0) d[j] += d[i] / free_n;
                d[i] = 0;
              end
            if (d[0] >= 0 && d[1] >= 0 && d[2] >= 0) begin
              top = (d[0] > d[1]) ? d[0] : d[1];
              if (d[2] > top) top = d[2];
              top += 65536;
              for (i = 0; i < 3; i++) if (!m[i] && pend[i]) d[i] -= top;
            end
            if (d[0] < 0 && d[0] < d[1]) begin
              if (d[0] < d[2]) cnt[0]++; else cnt[2]++;
            end else if (d[1] < 0) begin
              if (d[1] < d[2]) cnt[1]++; else cnt[2]++;
            end else if (d[2] < 0) cnt[2]++;
            else run = 0;
          end
        end
      end
    end
    return {3'b000, 7'(cnt[2]), 7'(cnt[1]), 7'(cnt[0])};
  endfunction

  assign waiting = counts_q.size();

  // Track registers, predict on each request, compare each result
  always @(posedge clk) begin
    logic [23:0] want;
    int idx;
    if (rst) begin
      for (idx = 0; idx < 3; idx++) begin
        lim_lo[idx] = 7'd0;
        lim_hi[idx] = 7'd64;
      end
      counts_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr >> 2;
        case (idx)
          REG_READ_MIN:   lim_lo[0] = pwdata[6:0];
          REG_READ_MAX:   lim_hi[0] = pwdata[6:0];
          REG_WRITE_MIN:  lim_lo[1] = pwdata[6:0];
          REG_WRITE_MAX:  lim_hi[1] = pwdata[6:0];
          REG_FORMAT_MIN: lim_lo[2] = pwdata[6:0];
          REG_FORMAT_MAX: lim_hi[2] = pwdata[6:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (counts_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = counts_q.pop_front();
          if (want[6:0] != m_tdata[6:0] || want[13:7] != m_tdata[13:7] ||
              want[20:14] != m_tdata[20:14] || m_tdata[23:21] != 3'b000) begin
            $display("%0t: counts mismatch, expected r%0d w%0d f%0d, actual r%0d w%0d f%0d",
                     $time, want[6:0], want[13:7], want[20:14],
                     m_tdata[6:0], m_tdata[13:7], m_tdata[20:14]);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) counts_q.push_back(apportion(s_tdata));
    end
  end
endmodule

[sim/tb_weighted_device_apportion.sv]
module tb_weighted_device_apportion;
  import wda_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, waiting, results_seen;
  int cycles = 0;
  int tx_idle = 0, rx_stall = 0;
  int hold_asked = 0, hold_given = 0, hold_left = 0;
  int sent = 0;
  int cur_min [3];

  weighted_device_apportion DUT (.*);

  wda_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_weighted_device_apportion: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_given < hold_asked) begin
      hold_given++;
      hold_left = 3000;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall);
    end
  end

  task automatic reg_write(input reg_idx_t idx, input int val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input int rl, rh, wl, wh, fl, fh);
    reg_write(REG_READ_MIN, rl);   reg_write(REG_READ_MAX, rh);
    reg_write(REG_WRITE_MIN, wl);  reg_write(REG_WRITE_MAX, wh);
    reg_write(REG_FORMAT_MIN, fl); reg_write(REG_FORMAT_MAX, fh);
    cur_min[0] = rl; cur_min[1] = wl; cur_min[2] = fl;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_req(input int n, msum, input bit rp, wp, fp,
                          input int rw, ww, fw);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, 17'(fw), 17'(ww), 17'(rw), fp, wp, rp, 8'(msum), 7'(n)};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly well-formed requests: weights sharing one, min sum from the limits
  task automatic random_req();
    bit p[3];
    int a, b, c, n, msum;
    p[0] = $urandom_range(1); p[1] = $urandom_range(1); p[2] = $urandom_range(1);
    n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64);
    if ($urandom_range(9) < 8) begin
      a = $urandom_range(65536);
      b = $urandom_range(65536 - a);
      c = 65536 - a - b;
      if ($urandom_range(9) < 7) begin
        if (!p[0]) a = 0;
        if (!p[1]) b = 0;
        if (!p[2]) c = 0;
      end
      msum = (p[0] ? cur_min[0] : 0) + (p[1] ? cur_min[1] : 0) + (p[2] ? cur_min[2] : 0);
      if ($urandom_range(4) == 0) msum = $urandom_range(255);
      send_req(n, msum, p[0], p[1], p[2], a, b, c);
    end else begin
      send_req($urandom_range(127), $urandom_range(255), p[0], p[1], p[2],
               $urandom_range(131071), $urandom_range(131071), $urandom_range(131071));
    end
  endtask

  initial begin
    int ph, i;
    cur_min[0] = 0; cur_min[1] = 0; cur_min[2] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, one and two devices, saturation, too few, no requests
    send_req(0, 0, 1, 1, 1, 20000, 20000, 25536);
    send_req(1, 0, 1, 1, 1, 65536, 0, 0);
    send_req(2, 0, 1, 1, 1, 40000, 20000, 5536);
    send_req(2, 0, 1, 1, 1, 10000, 40000, 15536);
    send_req(2, 0, 1, 1, 1, 10000, 20000, 35536);
    send_req(2, 0, 1, 1, 1, 30000, 30000, 5536);
    send_req(2, 0, 0, 1, 0, 65536, 0, 0);
    send_req(3, 0, 1, 1, 1, 21845, 21845, 21846);
    send_req(64, 0, 1, 1, 1, 21845, 21845, 21846);
    send_req(127, 0, 1, 1, 1, 30000, 30000, 5536);
    send_req(10, 0, 1, 1, 1, 131071, 131071, 131071);
    send_req(10, 255, 1, 1, 1, 30000, 20000, 15536);
    send_req(10, 0, 0, 0, 0, 30000, 20000, 15536);
    send_req(10, 0, 0, 1, 0, 30000, 0, 35536);
    send_req(7, 0, 1, 1, 1, 0, 0, 0);
    send_req(64, 0, 1, 0, 1, 65536, 65536, 65536);
    send_req(33, 0, 1, 1, 0, 1, 65535, 0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limits(0, 64, 0, 64, 0, 64);
        1: set_limits(2, 10, 1, 64, 3, 5);
        2: set_limits(64, 64, 0, 0, 0, 64);
        3: set_limits(10, 3, 0, 1, 5, 5);
        default: set_limits($urandom_range(64), $urandom_range(64), $urandom_range(64),
                            $urandom_range(64), $urandom_range(64), $urandom_range(64));
      endcase
      tx_idle  = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 29 : 0;
      rx_stall = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 29 : 0;
      // block fills up behind a receiver that holds off
      if (ph == 2) hold_asked++;
      for (i = 0; i < 72; i++) random_req();
      drain();
    end

    $display("covered %0d requests, %0d results, six limit settings incl. extremes and",
             sent, results_seen);
    $display("inverted ranges, under sender gaps, receiver stalls and a long hold-off");
    if (errors == 0)
      $display("tb_weighted_device_apportion: done, clean");
    else
      $display("tb_weighted_device_apportion: done, errors");
    $finish;
  end
endmodule

[files.f]
src/wda_pkg.sv
src/weighted_device_apportion.sv
sim/wda_checker.sv
sim/tb_weighted_device_apportion.sv
